// File: sv/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the sliding window median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned OUT_WIDTH = 8;
  localparam int unsigned IN_WIDTH  = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_SKIP,
    ST_FINISH
  } smf_state_t;

endpackage

// File: sv/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter
// Shifts each prediction into a window of the last WINDOW values and returns
// the window median, found by rank counting with one shared comparator.
// ----------------------------------------------------------------------------
//  channel      handshake                          payload
//  input        prediction_valid / prediction_ready prediction [7:0]
//  output       median_valid / median_ready         median_value [7:0]
//
//  each beat is worked out by the single comparator, which walks every
//  candidate against a rotating copy of the window, with a skip step
//  after each candidate
//  reset clears the window to zeros, so early medians count those zeros
//  a waiting result holds the block in its finish step; a new beat can be
//  taken while the previous result is still waiting on the output
module sliding_median_filter #(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned VALUE_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           prediction_valid,
  output logic                           prediction_ready,
  input  logic [smf_pkg::IN_WIDTH-1:0]   prediction,
  output logic                           median_valid,
  input  logic                           median_ready,
  output logic [smf_pkg::OUT_WIDTH-1:0]  median_value
);
  import smf_pkg::*;

  localparam int unsigned JW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam logic [JW-1:0] JLAST = JW'(WINDOW - 1);
  localparam logic [CW:0] K_LO = (CW + 1)'((WINDOW - 1) / 2);
  localparam logic [CW:0] K_HI = (CW + 1)'(WINDOW / 2);

  smf_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] window_values [WINDOW];
  logic [VALUE_WIDTH-1:0] ring [WINDOW];
  logic [VALUE_WIDTH-1:0] cand;
  logic [VALUE_WIDTH-1:0] lo_val;
  logic [VALUE_WIDTH-1:0] hi_val;
  logic [JW-1:0]          j_cnt;
  logic [JW-1:0]          i_cnt;
  logic [CW-1:0]          lt_cnt;
  logic [CW-1:0]          eq_cnt;

  logic                   in_beat;
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] pred_val;
  logic [VALUE_WIDTH-1:0] cand_sel;
  logic [CW-1:0]          lt_next;
  logic [CW-1:0]          eq_next;
  logic [CW:0]            upper;
  logic                   hit_lo;
  logic                   hit_hi;
  logic [VALUE_WIDTH:0]   mid_sum;

  assign in_beat  = prediction_valid && prediction_ready;
  assign out_load = (state == ST_FINISH) && (!median_valid || median_ready);
  assign pred_val = VALUE_WIDTH'(prediction);

  // candidate is captured from the ring head at the start of each pass
  assign cand_sel = (j_cnt == '0) ? ring[0] : cand;
  assign lt_next  = ((j_cnt == '0) ? '0 : lt_cnt) + CW'(ring[0] < cand_sel);
  assign eq_next  = ((j_cnt == '0) ? '0 : eq_cnt) + CW'(ring[0] == cand_sel);
  assign upper    = {1'b0, lt_next} + {1'b0, eq_next};
  assign hit_lo   = (K_LO >= {1'b0, lt_next}) && (K_LO < upper);
  assign hit_hi   = (K_HI >= {1'b0, lt_next}) && (K_HI < upper);
  assign mid_sum  = {1'b0, lo_val} + {1'b0, hi_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    prediction_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        prediction_ready = 1'b1;
        if (prediction_valid) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        if (j_cnt == JLAST) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (i_cnt == JLAST) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SORT;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // window shift line, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        window_values[k] <= '0;
      end
    end else if (in_beat) begin
      window_values[0] <= pred_val;
      for (int k = 1; k < WINDOW; k++) begin
        window_values[k] <= window_values[k-1];
      end
    end
  end

  // working copy rotates one place per cycle during sort and skip
  always_ff @(posedge clk) begin
    if (in_beat) begin
      ring[0] <= pred_val;
      for (int k = 1; k < WINDOW; k++) begin
        ring[k] <= window_values[k-1];
      end
    end else if (state == ST_SORT || state == ST_SKIP) begin
      ring[WINDOW-1] <= ring[0];
      for (int k = 0; k < WINDOW - 1; k++) begin
        ring[k] <= ring[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_cnt <= '0;
      i_cnt <= '0;
    end else if (in_beat) begin
      j_cnt <= '0;
      i_cnt <= '0;
    end else if (state == ST_SORT) begin
      j_cnt <= (j_cnt == JLAST) ? '0 : j_cnt + 1'b1;
    end else if (state == ST_SKIP) begin
      i_cnt <= i_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SORT) begin
      cand   <= cand_sel;
      lt_cnt <= lt_next;
      eq_cnt <= eq_next;
      if (j_cnt == JLAST) begin
        if (hit_lo) begin
          lo_val <= cand_sel;
        end
        if (hit_hi) begin
          hi_val <= cand_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (out_load) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_value <= OUT_WIDTH'(mid_sum >> 1);
    end
  end

`ifndef SYNTHESIS
  // a taken beat always starts the first candidate pass
  a_start_sort: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_SORT) && (j_cnt == '0) && (i_cnt == '0))
    else $error("sort did not start after input beat");

  // rank search must order the two middle values
  a_mid_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (lo_val <= hi_val))
    else $error("middle values out of order");

  // a new result only appears out of the finish step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(median_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside finish step");
`endif

endmodule

// File: tb/sv/sliding_median_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_median_filter_tb
// Drives predictions through the median filter with random gaps and stalls
// on both channels. Each accepted beat is run through a local window model
// and the median it gives, or a directed row's typed median, is queued.
// Results are checked in order against that queue.
// ----------------------------------------------------------------------------
module sliding_median_filter_tb;
  import smf_pkg::*;

  localparam int unsigned WINDOW      = 5;
  localparam int unsigned VALUE_WIDTH = 8;
  localparam int unsigned BEAT_CYCLES = WINDOW * (WINDOW + 1) + 2;
  localparam int unsigned N_DIRECTED  = 22;
  localparam int unsigned N_RANDOM    = 1130;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PAUSE_AT    = 600;

  typedef struct packed {
    logic [IN_WIDTH-1:0]  value;
    bit                   typed;
    logic [OUT_WIDTH-1:0] median;
  } stim_row_t;

  logic                 clk              = 1'b0;
  logic                 rst              = 1'b1;
  logic                 prediction_valid = 1'b0;
  logic                 prediction_ready;
  logic [IN_WIDTH-1:0]  prediction       = '0;
  logic                 median_valid;
  logic                 median_ready     = 1'b0;
  logic [OUT_WIDTH-1:0] median_value;

  logic [VALUE_WIDTH-1:0] window_model [WINDOW];
  logic [OUT_WIDTH-1:0]   median_pending [$];
  stim_row_t              directed_rows [N_DIRECTED];
  int unsigned            mismatch_count = 0;
  int unsigned            medians_taken  = 0;
  bit                     no_idle        = 1'b0;

  sliding_median_filter #(
    .WINDOW      (WINDOW),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .prediction_valid (prediction_valid),
    .prediction_ready (prediction_ready),
    .prediction       (prediction),
    .median_valid     (median_valid),
    .median_ready     (median_ready),
    .median_value     (median_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // shift the new value in, sort a copy, return the middle (or mean of two)
  function automatic logic [OUT_WIDTH-1:0] window_median_after(
    input logic [IN_WIDTH-1:0] value
  );
    logic [VALUE_WIDTH-1:0] ordered [WINDOW];
    logic [VALUE_WIDTH-1:0] swap;
    logic [VALUE_WIDTH:0]   pair_sum;
    logic [VALUE_WIDTH-1:0] mid;
    for (int k = WINDOW - 1; k > 0; k--) begin
      window_model[k] = window_model[k - 1];
    end
    window_model[0] = value[VALUE_WIDTH-1:0];
    for (int k = 0; k < WINDOW; k++) begin
      ordered[k] = window_model[k];
    end
    for (int a = 0; a < WINDOW - 1; a++) begin
      for (int b = a + 1; b < WINDOW; b++) begin
        if (ordered[a] > ordered[b]) begin
          swap       = ordered[a];
          ordered[a] = ordered[b];
          ordered[b] = swap;
        end
      end
    end
    if ((WINDOW % 2) == 1) begin
      mid = ordered[WINDOW / 2];
    end else begin
      pair_sum = {1'b0, ordered[(WINDOW - 1) / 2]} + {1'b0, ordered[WINDOW / 2]};
      mid      = pair_sum[VALUE_WIDTH:1];
    end
    return OUT_WIDTH'(mid);
  endfunction

  task automatic send_prediction(
    input logic [IN_WIDTH-1:0]  value,
    input bit                   typed,
    input logic [OUT_WIDTH-1:0] typed_median
  );
    int unsigned          gap;
    logic [OUT_WIDTH-1:0] predicted;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      prediction_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    prediction_valid <= 1'b1;
    prediction       <= value;
    do @(posedge clk); while (!(prediction_valid && prediction_ready));
    predicted = window_median_after(value);
    median_pending.push_back(typed ? typed_median : predicted);
  endtask

  // result side: random stall per beat, one long hold to back up the input
  initial begin
    int unsigned          stall;
    logic [OUT_WIDTH-1:0] wanted;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (medians_taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        median_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      median_ready <= 1'b1;
      do @(posedge clk); while (!(median_valid && median_ready));
      medians_taken++;
      if (median_pending.size() == 0) begin
        $error("median_value with no beat outstanding: actual %0d", median_value);
        mismatch_count++;
      end else begin
        wanted = median_pending.pop_front();
        if (median_value !== wanted) begin
          $error("median_value mismatch: expected %0d, actual %0d", wanted, median_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [IN_WIDTH-1:0] last_value;
    logic [IN_WIDTH-1:0] next_value;
    int unsigned         kind;

    // window starts at zeros, so the first medians read off directly
    directed_rows = '{
      '{8'd255, 1'b1, 8'd0},
      '{8'd255, 1'b1, 8'd0},
      '{8'd255, 1'b1, 8'd255},
      '{8'd0,   1'b1, 8'd255},
      '{8'd0,   1'b1, 8'd255},
      '{8'd0,   1'b1, 8'd0},
      '{8'd255, 1'b1, 8'd0},
      '{8'd128, 1'b0, 8'd0},
      '{8'd1,   1'b0, 8'd0},
      '{8'd128, 1'b0, 8'd0},
      '{8'd170, 1'b0, 8'd0},
      '{8'd85,  1'b0, 8'd0},
      '{8'd254, 1'b0, 8'd0},
      '{8'd127, 1'b0, 8'd0},
      '{8'd128, 1'b0, 8'd0},
      '{8'd128, 1'b0, 8'd0},
      '{8'd2,   1'b0, 8'd0},
      '{8'd7,   1'b0, 8'd0},
      '{8'd7,   1'b0, 8'd0},
      '{8'd7,   1'b0, 8'd0},
      '{8'd7,   1'b0, 8'd0},
      '{8'd7,   1'b1, 8'd7}
    };
    for (int k = 0; k < WINDOW; k++) begin
      window_model[k] = '0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_prediction(directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].median);
    end

    last_value = 8'd7;
    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 700 && n < 800);
      if (n == PAUSE_AT) begin
        prediction_valid <= 1'b0;
        while (median_pending.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: next_value = IN_WIDTH'($urandom);
        4, 5:       next_value = IN_WIDTH'($urandom_range(0, 3));
        6:          next_value = $urandom_range(0, 1) ? '1 : '0;
        7:          next_value = last_value + IN_WIDTH'($urandom_range(0, 6)) - 8'd3;
        default:    next_value = last_value;
      endcase
      send_prediction(next_value, 1'b0, '0);
      last_value = next_value;
    end
    prediction_valid <= 1'b0;

    while (median_pending.size() != 0) @(posedge clk);
    repeat (2 * BEAT_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
